// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL in this folder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is released.
`define ASSERT_ON(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("assertion failed");

`endif

// ===== rtl/core/bedm_pkg.sv =====
// ---------------------------------------------------------------------------
// bedm_pkg
// Types, codes and helpers shared by the bounded edit distance matcher.
// ---------------------------------------------------------------------------
`default_nettype none

package bedm_pkg;

	localparam int CHAR_BITS     = 21;
	localparam int DIST_BITS     = 4;
	localparam int SLOT_BITS     = 5;
	localparam int OP_BITS       = 2;
	localparam int MAXD_BITS     = 3;
	localparam int QLEN_BITS     = 6;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 6;
	localparam int OUT_DIST_BITS = 4;

	// max_distance after reset is 1, so the row cap after reset is 2
	localparam logic [MAXD_BITS-1:0] MAXD_RESET = 3'd1;
	localparam int                   RESET_CAP  = 2;

	typedef logic [CHAR_BITS-1:0] char_t;
	typedef logic [DIST_BITS-1:0] dist_t;

	typedef enum logic [OP_BITS-1:0] {
		OP_LOAD    = 2'd0,
		OP_RESTART = 2'd1,
		OP_FEED    = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_MAX_DISTANCE       = 2'd0,
		CFG_TRANSPOSITION_MODE = 2'd1,
		CFG_QUERY_LENGTH       = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [OP_BITS-1:0]   operation;
		logic [SLOT_BITS-1:0] slot;
		logic [CHAR_BITS-1:0] char_code;
	} req_t;

	typedef struct packed {
		logic                     is_match;
		logic                     can_match;
		logic [OUT_DIST_BITS-1:0] distance;
	} rsp_t;

	// per-item controls broadcast to every cell for the whole wave
	typedef struct packed {
		op_t                  op;
		logic [SLOT_BITS-1:0] slot;
		char_t                ch;
		char_t                prev_ch;
		logic                 prev_ch_valid;
		logic                 trans;
		logic [MAXD_BITS-1:0] max_dist;
		dist_t                cap;
		logic                 dead;
	} ctl_t;

	// data handed from one cell to its right neighbor
	typedef struct packed {
		logic  valid;
		dist_t next;   // new entry of the sending cell
		dist_t cur;    // old entry of the sending cell
		dist_t prev;   // old previous-row entry of the sending cell
		dist_t lprev;  // old previous-row entry one more to the left
		char_t qch;    // query character held by the sending cell
		logic  any;    // some entry so far within max_distance
		dist_t fin;    // capped entry at the query length
	} tok_t;

	function automatic dist_t dmin(input dist_t a, input dist_t b);
		return (a < b) ? a : b;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bedm_cell.sv =====
// ---------------------------------------------------------------------------
// bedm_cell
// One column of the distance row: holds its entries and query character,
// updates them when the wave passes and hands the result to the right.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bedm_cell
	import bedm_pkg::*;
#(
	parameter int IDX   = 0,
	parameter int LEN_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_t             ctl,
	input  logic [LEN_W-1:0] len,
	input  tok_t             tok_in,
	output tok_t             tok_out
);

	localparam logic [LEN_W-1:0] IDX_L    = LEN_W'(IDX);
	localparam dist_t            RST_CUR  = dist_t'((IDX < RESET_CAP) ? IDX : RESET_CAP);
	localparam dist_t            RST_PREV = dist_t'(RESET_CAP);

	dist_t cur_q;
	dist_t prev_q;
	char_t q_q;
	tok_t  tok_q;

	logic [DIST_BITS:0] up_w;
	logic [DIST_BITS:0] diag_w;
	logic [DIST_BITS:0] left_w;
	logic [DIST_BITS:0] swap_w;
	logic [DIST_BITS:0] best_w;
	logic               swap_ok;
	logic               in_len;
	logic               load_hit;
	dist_t              nxt;
	dist_t              rst_val;
	dist_t              cur_new;
	dist_t              prev_new;

	assign in_len   = (IDX_L <= len);
	assign load_hit = (IDX > 0) && (int'(ctl.slot) == IDX - 1);
	assign rst_val  = (int'(ctl.cap) > IDX) ? dist_t'(IDX) : ctl.cap;

	always_comb begin
		up_w    = {1'b0, dmin(cur_q, ctl.cap)} + (DIST_BITS+1)'(1);
		diag_w  = {1'b0, dmin(tok_in.cur, ctl.cap)} + {{DIST_BITS{1'b0}}, (q_q != ctl.ch)};
		left_w  = {1'b0, tok_in.next} + (DIST_BITS+1)'(1);
		swap_w  = {1'b0, dmin(tok_in.lprev, ctl.cap)} + (DIST_BITS+1)'(1);
		swap_ok = ctl.trans && ctl.prev_ch_valid && (IDX > 1) &&
			(tok_in.qch == ctl.ch) && (q_q == ctl.prev_ch);
		if (IDX == 0) begin
			best_w = up_w;
		end else begin
			best_w = (diag_w < up_w) ? diag_w : up_w;
			if (left_w < best_w) begin
				best_w = left_w;
			end
			if (swap_ok && (swap_w < best_w)) begin
				best_w = swap_w;
			end
		end
		nxt = (best_w > {1'b0, ctl.cap}) ? ctl.cap : best_w[DIST_BITS-1:0];
	end

	always_comb begin
		cur_new  = cur_q;
		prev_new = prev_q;
		case (ctl.op)
			OP_RESTART: begin
				cur_new  = rst_val;
				prev_new = ctl.cap;
			end
			OP_FEED: begin
				if (!ctl.dead) begin
					cur_new  = in_len ? nxt : ctl.cap;
					prev_new = cur_q;
				end
			end
			default: begin
				cur_new  = cur_q;
				prev_new = prev_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= RST_CUR;
			prev_q <= RST_PREV;
			tok_q  <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			if (tok_in.valid) begin
				cur_q  <= cur_new;
				prev_q <= prev_new;
				tok_q.next  <= cur_new;
				tok_q.cur   <= cur_q;
				tok_q.prev  <= prev_q;
				tok_q.lprev <= tok_in.prev;
				tok_q.qch   <= (IDX == 0) ? '0 : q_q;
				tok_q.any   <= tok_in.any || (in_len && (cur_new <= dist_t'(ctl.max_dist)));
				tok_q.fin   <= (IDX_L == len) ? dmin(cur_new, ctl.cap) : tok_in.fin;
			end
		end
	end

	// query character store, undefined until loaded
	always_ff @(posedge clk) begin
		if (tok_in.valid && (ctl.op == OP_LOAD) && load_hit) begin
			q_q <= ctl.ch;
		end
	end

	assign tok_out = tok_q;

	`ASSERT_ON(a_row_hold, clk, arst_n, !tok_in.valid |=> $stable(cur_q))

endmodule

`default_nettype wire

// ===== rtl/core/bounded_edit_distance_matcher.sv =====
// ---------------------------------------------------------------------------
// bounded_edit_distance_matcher
// Bounded Levenshtein / restricted Damerau matcher over a row of column cells.
// ---------------------------------------------------------------------------
// channel   dir  handshake          payload
// req       in   req_valid/stall    req_t: operation, slot, char_code
// rsp       out  rsp_valid/stall    rsp_t: is_match, can_match, distance
// cfg       in   cfg_valid/ready    cfg_index, cfg_data
//
// Every request sends one wave through MAX_QUERY_CHARS+1 cells, one cell a
// cycle; the response is registered from the last cell's output, and the
// next request is taken in the cycle its predecessor's response lands, so
// only one request is in flight at a time.
// A stalled response waits in a hold register; req_stall stays high meanwhile.
// Reset sets the row to min(index, 2), the previous row to 2; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bounded_edit_distance_matcher
	import bedm_pkg::*;
#(
	parameter int MAX_QUERY_CHARS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  req_t                     req,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output rsp_t                     rsp,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	localparam int CELLS = MAX_QUERY_CHARS + 1;
	localparam int LEN_W = $clog2(MAX_QUERY_CHARS + 1);

	logic [MAXD_BITS-1:0] max_dist_q;
	logic                 trans_q;
	logic [QLEN_BITS-1:0] qlen_q;

	op_t                  op_q;
	logic [SLOT_BITS-1:0] slot_q;
	char_t                ch_q;
	char_t                prev_ch_q;
	logic                 prev_ch_valid_q;
	logic                 dead_q;
	logic                 start_q;
	logic                 busy_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;
	logic                 hold_v_q;
	rsp_t                 hold_q;

	logic             accept;
	logic             done;
	logic             out_free;
	logic             dead_next;
	logic [LEN_W-1:0] len;
	dist_t            cap;
	ctl_t             ctl;
	rsp_t             res;
	tok_t             tok [CELLS+1];

	assign accept    = req_valid && !req_stall;
	assign req_stall = busy_q;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign cap = dist_t'(max_dist_q) + dist_t'(1);
	assign len = (int'(qlen_q) > MAX_QUERY_CHARS) ? LEN_W'(MAX_QUERY_CHARS) : LEN_W'(qlen_q);

	always_comb begin
		ctl.op            = op_q;
		ctl.slot          = slot_q;
		ctl.ch            = ch_q;
		ctl.prev_ch       = prev_ch_q;
		ctl.prev_ch_valid = prev_ch_valid_q;
		ctl.trans         = trans_q;
		ctl.max_dist      = max_dist_q;
		ctl.cap           = cap;
		ctl.dead          = dead_q;
	end

	always_comb begin
		tok[0]       = '0;
		tok[0].valid = start_q;
	end

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		bedm_cell #(
			.IDX   (i),
			.LEN_W (LEN_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.len     (len),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	assign done = tok[CELLS].valid;

	always_comb begin
		case (op_q)
			OP_RESTART: dead_next = 1'b0;
			OP_FEED:    dead_next = dead_q || !tok[CELLS].any;
			default:    dead_next = dead_q;
		endcase
		if (dead_next) begin
			res.is_match  = 1'b0;
			res.can_match = 1'b0;
			res.distance  = OUT_DIST_BITS'(cap);
		end else begin
			res.is_match  = (tok[CELLS].fin <= dist_t'(max_dist_q));
			res.can_match = tok[CELLS].any;
			res.distance  = OUT_DIST_BITS'(tok[CELLS].fin);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dist_q <= MAXD_RESET;
			trans_q    <= 1'b0;
			qlen_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MAX_DISTANCE:       max_dist_q <= cfg_data[MAXD_BITS-1:0];
				CFG_TRANSPOSITION_MODE: trans_q    <= cfg_data[0];
				CFG_QUERY_LENGTH:       qlen_q     <= cfg_data[QLEN_BITS-1:0];
				default:                ;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(req.operation);
			slot_q <= req.slot;
			ch_q   <= req.char_code;
		end
	end

	// matcher status and flow control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ch_q       <= '0;
			prev_ch_valid_q <= 1'b0;
			dead_q          <= 1'b0;
			start_q         <= 1'b0;
			busy_q          <= 1'b0;
			rsp_valid_q     <= 1'b0;
			hold_v_q        <= 1'b0;
		end else begin
			start_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end
			if (done) begin
				dead_q <= dead_next;
				if (op_q == OP_RESTART) begin
					prev_ch_q       <= '0;
					prev_ch_valid_q <= 1'b0;
				end else if ((op_q == OP_FEED) && !dead_q) begin
					prev_ch_q       <= ch_q;
					prev_ch_valid_q <= 1'b1;
				end
			end
			if (done) begin
				if (out_free) begin
					rsp_valid_q <= 1'b1;
					busy_q      <= 1'b0;
				end else begin
					hold_v_q <= 1'b1;
				end
			end else if (hold_v_q && out_free) begin
				rsp_valid_q <= 1'b1;
				hold_v_q    <= 1'b0;
				busy_q      <= 1'b0;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (done) begin
			if (out_free) begin
				rsp_q <= res;
			end else begin
				hold_q <= res;
			end
		end else if (hold_v_q && out_free) begin
			rsp_q <= hold_q;
		end
	end

	`ASSERT_ON(a_done_busy, clk, arst_n, done |-> busy_q)
	`ASSERT_ON(a_hold_full, clk, arst_n, hold_v_q |-> rsp_valid_q)
	`ASSERT_ON(a_restart_live, clk, arst_n, (done && (op_q == OP_RESTART)) |=> !dead_q)

endmodule

`default_nettype wire
